// ===== hw/rtl/r2fft_pkg.sv =====
// Shared constants, types, twiddle functions and bit reversal of the radix-2 FFT block.
`default_nettype none

package r2fft_pkg;

  // Frame size and field widths.
  localparam int MAX_LG  = 6;
  localparam int NPTS    = 1 << MAX_LG;
  localparam int IDX_W   = MAX_LG;
  localparam int LG_W    = 3;
  localparam int BF_W    = MAX_LG - 1;
  localparam int SMP_W   = 16;
  localparam int OUT_W   = 22;
  // Working precision: 16-bit input grown by six stages and the sqrt(2) of a complex rotation.
  localparam int DW      = 24;
  // Twiddles carry one extra integer bit so that 1.0 is held exactly.
  localparam int TW_FRAC = 15;
  localparam int TW_W    = TW_FRAC + 2;
  localparam int PROD_W  = TW_W + DW;

  // Configuration register indexes (word address bit 2).
  localparam logic REG_LOG2_POINTS  = 1'b0;
  localparam logic REG_INVERSE_MODE = 1'b1;

  typedef logic signed [DW-1:0]   dat_t;
  typedef logic signed [TW_W-1:0] tw_t;
  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [OUT_W-1:0] bin_t;

  typedef struct packed {
    dat_t re;
    dat_t im;
  } cplx_t;

  // round(cos(pi*k/32) * 2^15) for k in 0..16.
  function automatic tw_t cos_lut(input logic [4:0] k);
    tw_t v;
    case (k)
      5'd0:    v = 17'sd32768;
      5'd1:    v = 17'sd32610;
      5'd2:    v = 17'sd32138;
      5'd3:    v = 17'sd31357;
      5'd4:    v = 17'sd30274;
      5'd5:    v = 17'sd28899;
      5'd6:    v = 17'sd27246;
      5'd7:    v = 17'sd25330;
      5'd8:    v = 17'sd23170;
      5'd9:    v = 17'sd20788;
      5'd10:   v = 17'sd18205;
      5'd11:   v = 17'sd15447;
      5'd12:   v = 17'sd12540;
      5'd13:   v = 17'sd9512;
      5'd14:   v = 17'sd6393;
      5'd15:   v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // Cosine of 2*pi*m/64 for m in 0..31.
  function automatic tw_t tw_cos(input logic [4:0] m);
    tw_t v;
    if (m <= 5'd16) begin
      v = cos_lut(m);
    end else begin
      v = -cos_lut(5'(6'd32 - {1'b0, m}));
    end
    return v;
  endfunction

  // Sine of 2*pi*m/64 for m in 0..31.
  function automatic tw_t tw_sin(input logic [4:0] m);
    tw_t v;
    if (m <= 5'd16) begin
      v = cos_lut(5'd16 - m);
    end else begin
      v = cos_lut(m - 5'd16);
    end
    return v;
  endfunction

  // Reverse the low lg bits of an index.
  function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] p,
                                               input logic [LG_W-1:0] lg);
    logic [IDX_W-1:0] r;
    for (int b = 0; b < IDX_W; b++) begin
      r[IDX_W-1-b] = p[b];
    end
    return r >> (LG_W'(MAX_LG) - lg);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/r2fft_if.sv =====
// Handshake interfaces for the sample channel and the bin channel.
`default_nettype none

interface r2fft_smp_if
  import r2fft_pkg::*;
  ;
  logic valid;
  logic ready;
  smp_t sample_re;
  smp_t sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

interface r2fft_bin_if
  import r2fft_pkg::*;
  ;
  logic valid;
  logic ready;
  bin_t bin_re;
  bin_t bin_im;
  logic last_bin;

  modport source (output valid, output bin_re, output bin_im, output last_bin, input ready);
  modport sink (input valid, input bin_re, input bin_im, input last_bin, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/radix2_fft_with_inverse.sv =====
// Top level of the in-place radix-2 decimation-in-time FFT with inverse mode.
// Samples load one per cycle; the frame of N = 2^lg samples then runs lg*N/2 butterflies
// on the dual-read point memory, each through the states read, multiply, add and write-back,
// and the N bins then leave through read, calculate and send, each bin held until taken.
// No new sample is accepted until the last bin of the frame has left.
// Synchronous active-low reset returns to loading with an empty frame, length 64, forward mode.
`default_nettype none

module radix2_fft_with_inverse
  import r2fft_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  r2fft_smp_if.sink         in_if,
  r2fft_bin_if.source       out_if,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_WRB   = 8'b0001_0000,
    S_ORD   = 8'b0010_0000,
    S_OCALC = 8'b0100_0000,
    S_OSEND = 8'b1000_0000
  } state_t;

  localparam logic signed [PROD_W:0] RND_HALF = (PROD_W+1)'(1) <<< (TW_FRAC - 1);
  localparam logic signed [DW:0] OUT_MAX = (DW+1)'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [DW:0] OUT_MIN = -(DW+1)'(1 << (OUT_W - 1));

  state_t state_r, state_nxt;
  logic [LG_W-1:0]  lg_cfg_r;
  logic             inv_cfg_r;
  logic [LG_W-1:0]  lg_r;
  logic             inv_r;
  logic [IDX_W-1:0] cnt_r;
  logic [LG_W-1:0]  stage_r;
  logic [BF_W-1:0]  bf_r;
  logic [IDX_W-1:0] k_r;

  // Point memory: one write port, two registered read ports.
  cplx_t mem [NPTS];
  cplx_t rd_a_r, rd_b_r;
  logic             we;
  logic [IDX_W-1:0] waddr;
  cplx_t            wdata;
  logic [IDX_W-1:0] raddr_a, raddr_b;

  // Butterfly pipeline registers.
  cplx_t a_r, diff_r;
  logic signed [PROD_W-1:0] p_cr_r, p_si_r, p_ci_r, p_sr_r;

  // Output register.
  bin_t bin_re_r, bin_im_r;
  logic last_r;

  logic [LG_W-1:0]  lg_eff;
  logic [IDX_W:0]   n_eff;
  logic             frame_done;
  logic             in_acc;
  logic [BF_W-1:0]  half_mask;
  logic [BF_W-1:0]  bf_low;
  logic [IDX_W-1:0] pa, pb;
  logic [IDX_W-1:0] phys_a, phys_b;
  logic [4:0]       tw_idx;
  tw_t              tw_c, tw_s;
  logic             conj_now;
  dat_t             bi_in, ai_in;
  logic signed [PROD_W:0] sum_r, sum_i;
  dat_t             tr, ti;
  logic             last_bf;
  logic             last_k;
  logic signed [DW:0] oreal, oimag, sreal, simag;

  // Rounding arithmetic right shift, ties toward plus infinity.
  function automatic logic signed [DW:0] rnd_shift(input logic signed [DW:0] v,
                                                   input logic [LG_W-1:0] sh);
    logic signed [DW:0] r;
    r = v;
    if (sh != '0) begin
      r = (v + ((DW+1)'(1) <<< (sh - LG_W'(1)))) >>> sh;
    end
    return r;
  endfunction

  function automatic bin_t sat_out(input logic signed [DW:0] v);
    logic signed [DW:0] r;
    r = v;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end
    return OUT_W'(r);
  endfunction

  // Frame length in force and frame completion.
  assign lg_eff     = (lg_cfg_r > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : lg_cfg_r;
  assign n_eff      = (IDX_W+1)'(1) << lg_eff;
  assign frame_done = ({1'b0, cnt_r} + (IDX_W+1)'(1)) >= n_eff;
  assign in_acc     = in_if.valid && in_if.ready;

  // Butterfly addressing: insert a zero at bit stage-1 of the butterfly count.
  assign half_mask = (BF_W'(1) << (stage_r - LG_W'(1))) - BF_W'(1);
  assign bf_low    = bf_r & half_mask;
  assign pa        = ({1'b0, bf_r & ~half_mask} << 1) | {1'b0, bf_low};
  assign pb        = pa | (IDX_W'(1) << (stage_r - LG_W'(1)));
  assign phys_a    = bit_rev(pa, lg_r);
  assign phys_b    = bit_rev(pb, lg_r);
  assign tw_idx    = 5'(bf_low << (LG_W'(MAX_LG) - stage_r));
  assign tw_c      = tw_cos(tw_idx);
  assign tw_s      = tw_sin(tw_idx);
  assign last_bf   = bf_r == BF_W'(((IDX_W+1)'(1) << (lg_r - LG_W'(1))) - (IDX_W+1)'(1));
  assign last_k    = k_r == IDX_W'(((IDX_W+1)'(1) << lg_r) - (IDX_W+1)'(1));

  // Inverse mode conjugates the samples as the first stage reads them.
  assign conj_now = inv_r && (stage_r == LG_W'(1));
  assign bi_in    = conj_now ? -rd_b_r.im : rd_b_r.im;
  assign ai_in    = conj_now ? -rd_a_r.im : rd_a_r.im;

  // Twiddle product sums, rounded to nearest.
  assign sum_r = (PROD_W+1)'(p_cr_r) + (PROD_W+1)'(p_si_r) + RND_HALF;
  assign sum_i = (PROD_W+1)'(p_ci_r) - (PROD_W+1)'(p_sr_r) + RND_HALF;
  assign tr    = DW'(sum_r >>> TW_FRAC);
  assign ti    = DW'(sum_i >>> TW_FRAC);

  // Read addresses: the output pass uses port a.
  assign raddr_a = state_r[5] ? bit_rev(k_r, lg_r) : phys_a;
  assign raddr_b = phys_b;

  // Write port select.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = '{re: DW'(in_if.sample_re), im: DW'(in_if.sample_im)};
    unique case (state_r)
      S_LOAD: begin
        we = in_acc;
      end
      S_ADD: begin
        we    = 1'b1;
        waddr = phys_a;
        wdata = '{re: a_r.re + tr, im: a_r.im + ti};
      end
      S_WRB: begin
        we    = 1'b1;
        waddr = phys_b;
        wdata = diff_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // Output value: undo the conjugation and divide by N in inverse mode.
  always_comb begin
    oreal = (DW+1)'(rd_a_r.re);
    oimag = (inv_r && lg_r != '0) ? -(DW+1)'(rd_a_r.im) : (DW+1)'(rd_a_r.im);
    sreal = inv_r ? rnd_shift(oreal, lg_r) : oreal;
    simag = inv_r ? rnd_shift(oimag, lg_r) : oimag;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && frame_done) begin
          state_nxt = (lg_eff == '0) ? S_ORD : S_RD;
        end
      end
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_WRB;
      S_WRB: begin
        state_nxt = (last_bf && stage_r == lg_r) ? S_ORD : S_RD;
      end
      S_ORD:   state_nxt = S_OCALC;
      S_OCALC: state_nxt = S_OSEND;
      S_OSEND: begin
        if (out_if.ready) begin
          state_nxt = last_k ? S_LOAD : S_ORD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      lg_cfg_r  <= LG_W'(MAX_LG);
      inv_cfg_r <= 1'b0;
      lg_r      <= '0;
      inv_r     <= 1'b0;
      cnt_r     <= '0;
      stage_r   <= '0;
      bf_r      <= '0;
      k_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_LOG2_POINTS:  lg_cfg_r  <= pwdata[LG_W-1:0];
          REG_INVERSE_MODE: inv_cfg_r <= pwdata[0];
          default:          lg_cfg_r  <= lg_cfg_r;
        endcase
      end
      if (state_r == S_LOAD && in_acc) begin
        if (frame_done) begin
          cnt_r   <= '0;
          lg_r    <= lg_eff;
          inv_r   <= inv_cfg_r;
          stage_r <= LG_W'(1);
          bf_r    <= '0;
          k_r     <= '0;
        end else begin
          cnt_r <= cnt_r + IDX_W'(1);
        end
      end
      if (state_r == S_WRB) begin
        if (last_bf) begin
          stage_r <= stage_r + LG_W'(1);
          bf_r    <= '0;
        end else begin
          bf_r <= bf_r + BF_W'(1);
        end
      end
      if (state_r == S_OSEND && out_if.ready) begin
        k_r <= k_r + IDX_W'(1);
      end
    end
  end

  // Datapath registers: products, butterfly difference, output bin.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      p_cr_r <= tw_c * rd_b_r.re;
      p_si_r <= tw_s * bi_in;
      p_ci_r <= tw_c * bi_in;
      p_sr_r <= tw_s * rd_b_r.re;
      a_r    <= '{re: rd_a_r.re, im: ai_in};
    end
    if (state_r == S_ADD) begin
      diff_r <= '{re: a_r.re - tr, im: a_r.im - ti};
    end
    if (state_r == S_OCALC) begin
      bin_re_r <= sat_out(sreal);
      bin_im_r <= sat_out(simag);
      last_r   <= last_k;
    end
  end

  // Handshakes and register read-back.
  assign in_if.ready     = state_r == S_LOAD;
  assign out_if.valid    = state_r == S_OSEND;
  assign out_if.bin_re   = bin_re_r;
  assign out_if.bin_im   = bin_im_r;
  assign out_if.last_bin = last_r;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == REG_INVERSE_MODE) ? {31'b0, inv_cfg_r}
                                                         : {29'b0, lg_cfg_r};

endmodule

`default_nettype wire

// ===== hw/rtl/r2fft_chk.sv =====
// Port-level checker for the FFT block and its bind to the top level.
`default_nettype none

module r2fft_chk
  import r2fft_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire bin_t bin_re,
  input wire bin_t bin_im,
  input wire logic last_bin
);

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a bin is offered");

  // Reset leaves no bin offered.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("bin offered right after reset");

  // A stalled bin holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bin_re) && $stable(bin_im)
      && $stable(last_bin))
    else $error("stalled bin changed");

  // After the final bin the block goes back to loading.
  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_bin |=> in_ready && !out_valid)
    else $error("no return to loading after the final bin");

  // Each transfer of a bin that is not final is followed by a gap.
  a_bin_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_bin |=> !out_valid && !in_ready)
    else $error("bin sequence broken");

endmodule

bind radix2_fft_with_inverse r2fft_chk u_r2fft_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .bin_re    (out_if.bin_re),
  .bin_im    (out_if.bin_im),
  .last_bin  (out_if.last_bin)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the radix-2 FFT block with inverse mode.
`timescale 1ns / 1ps

module tb;
  import r2fft_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_LOG2_POINTS = {REG_LOG2_POINTS, 2'b00};
  localparam logic [2:0] ADDR_INVERSE_MODE = {REG_INVERSE_MODE, 2'b00};

  typedef struct {
    logic signed [21:0] re;
    logic signed [21:0] im;
    logic last;
  } bin_rec_t;

  r2fft_smp_if smp_ch ();
  r2fft_bin_if bin_ch ();

  radix2_fft_with_inverse u_top (
    .clk(clk), .rst_n(rst_n), .in_if(smp_ch.sink), .out_if(bin_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: loaded samples, fill count and register copies.
  longint frame_re[NPTS];
  longint frame_im[NPTS];
  int fill_count = 0;
  int cur_log2 = 6;
  bit cur_inverse = 1'b0;
  bin_rec_t expected_bins[$];
  int errors = 0;
  int bins_seen = 0;
  int frames_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat22(longint v);
    if (v > 2097151) return 2097151;
    if (v < -2097152) return -2097152;
    return v;
  endfunction

  // Twiddle cosine table, round(cos(pi*k/32) * 2^15).
  function automatic longint cos_tab(int k);
    longint t[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                      20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    return t[k];
  endfunction

  // Run the FFT on the completed frame and queue its bins.
  task automatic compute_frame_bins();
    longint xr[NPTS];
    longint xi[NPTS];
    longint tmp, c, s, br, bi, tr, ti, ar, ai;
    int lg, n, r, half, m;
    bin_rec_t rec;
    lg = (cur_log2 > MAX_LG) ? MAX_LG : cur_log2;
    n = 1 << lg;
    for (int k = 0; k < n; k++) begin
      xr[k] = frame_re[k];
      xi[k] = cur_inverse ? -frame_im[k] : frame_im[k];
    end
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (r > i) begin
        tmp = xr[i]; xr[i] = xr[r]; xr[r] = tmp;
        tmp = xi[i]; xi[i] = xi[r]; xi[r] = tmp;
      end
    end
    for (int st = 1; st <= lg; st++) begin
      half = 1 << (st - 1);
      for (int i = 0; i < n; i += 2 * half) begin
        for (int j = 0; j < half; j++) begin
          m = (j << (6 - st)) & 31;
          if (m <= 16) begin
            c = cos_tab(m);
            s = cos_tab(16 - m);
          end else begin
            c = -cos_tab(32 - m);
            s = cos_tab(m - 16);
          end
          br = xr[i + j + half];
          bi = xi[i + j + half];
          tr = rnd_shift(c * br + s * bi, 15);
          ti = rnd_shift(c * bi - s * br, 15);
          ar = xr[i + j];
          ai = xi[i + j];
          xr[i + j] = ar + tr;
          xi[i + j] = ai + ti;
          xr[i + j + half] = ar - tr;
          xi[i + j + half] = ai - ti;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      if (cur_inverse) begin
        xr[k] = rnd_shift(xr[k], lg);
        xi[k] = rnd_shift(-xi[k], lg);
      end
      rec.re = 22'(sat22(xr[k]));
      rec.im = 22'(sat22(xi[k]));
      rec.last = (k == n - 1);
      expected_bins.push_back(rec);
    end
  endtask

  // Predict the effect of one accepted sample.
  task automatic accept_sample(logic signed [15:0] re, logic signed [15:0] im);
    int lg;
    lg = (cur_log2 > MAX_LG) ? MAX_LG : cur_log2;
    frame_re[fill_count] = re;
    frame_im[fill_count] = im;
    fill_count++;
    if (fill_count >= (1 << lg)) begin
      fill_count = 0;
      frames_done++;
      compute_frame_bins();
    end
  endtask

  // Register write over the configuration port: setup, then access.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_LOG2_POINTS) cur_log2 = data[2:0];
    else cur_inverse = data[0];
  endtask

  // Send one sample, with optional idle cycles ahead of it.
  // Valid stays high between back-to-back samples.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.sample_re <= re;
    smp_ch.sample_im <= im;
    do @(posedge clk); while (!smp_ch.ready);
    accept_sample(re, im);
  endtask

  // Wait until every predicted bin has arrived, then let the block settle.
  task automatic drain();
    int guard;
    guard = 0;
    smp_ch.valid <= 1'b0;
    while (expected_bins.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (1600) @(posedge clk);
  endtask

  task automatic configure(int lg, bit inv);
    write_reg(ADDR_LOG2_POINTS, 32'(lg));
    write_reg(ADDR_INVERSE_MODE, 32'(inv));
  endtask

  function automatic logic signed [15:0] rnd_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(63)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Extremes, impulse and both modes at several frame lengths.
  task automatic test_directed();
    configure(3, 1'b0);
    send_sample(16'sh7fff, 16'sh8000);
    for (int i = 1; i < 8; i++) send_sample(16'sd0, 16'sd0);
    for (int i = 0; i < 8; i++) send_sample(16'sh8000, 16'sh8000);
    drain();
    configure(2, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(16'sh7fff, (i & 1) ? 16'sh8000 : 16'sh7fff);
    drain();
    configure(0, 1'b1);
    send_sample(16'sh5555, 16'shaaaa);
    drain();
    configure(7, 1'b0);
    drain();
  endtask

  // Full-size frames at the extreme length, forward and inverse.
  task automatic test_full_frames();
    configure(6, 1'b0);
    for (int i = 0; i < 64; i++) send_sample(rnd_value(), rnd_value());
    drain();
    configure(7, 1'b1);
    for (int i = 0; i < 64; i++) send_sample(rnd_value(), rnd_value());
    drain();
  endtask

  // Random frames of 1 to 16 samples under one idling profile.
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    configure($urandom_range(4), 1'($urandom));
    for (int i = 0; i < count; i++) send_sample(rnd_value(), rnd_value());
    // Complete any partial frame so no samples stay stranded.
    while (fill_count != 0) send_sample(rnd_value(), rnd_value());
    drain();
  endtask

  // Receiver ready with random stalls; compare each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      bin_ch.ready <= 1'b0;
    end else begin
      if (bin_ch.valid && bin_ch.ready) begin
        bins_seen++;
        if (expected_bins.size() == 0) begin
          $error("unexpected bin re=%0d im=%0d", bin_ch.bin_re, bin_ch.bin_im);
          errors++;
        end else begin
          bin_rec_t e;
          e = expected_bins.pop_front();
          if (bin_ch.bin_re !== e.re) begin
            $error("bin_re expected %0d actual %0d", e.re, bin_ch.bin_re);
            errors++;
          end
          if (bin_ch.bin_im !== e.im) begin
            $error("bin_im expected %0d actual %0d", e.im, bin_ch.bin_im);
            errors++;
          end
          if (bin_ch.last_bin !== e.last) begin
            $error("last_bin expected %0d actual %0d", e.last, bin_ch.last_bin);
            errors++;
          end
        end
      end
      bin_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    smp_ch.valid = 1'b0;
    smp_ch.sample_re = '0;
    smp_ch.sample_im = '0;
    bin_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_frames();
    test_random_phase(0, 0, 12);
    test_random_phase(64, 0, 12);
    test_random_phase(0, 64, 12);
    test_random_phase(17, 17, 12);
    if (expected_bins.size() != 0) begin
      $error("%0d bins never arrived", expected_bins.size());
      errors++;
    end
    $display("Covered %0d frames and %0d bins over lengths 1 to 64, both modes,",
             frames_done, bins_seen);
    $display("with sender idling and receiver stalls.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
